// File: rtl/ttl_pkg.sv
`default_nettype none

package ttl_pkg;

   // Operation codes carried on req_func.
   localparam logic [1:0] FUNC_GENERATE = 2'd0;
   localparam logic [1:0] FUNC_RENEW    = 2'd1;
   localparam logic [1:0] FUNC_COUNT    = 2'd2;

   // Result codes carried on rsp_status.
   localparam logic [1:0] STATUS_DONE          = 2'd0;
   localparam logic [1:0] STATUS_FULL          = 2'd1;
   localparam logic [1:0] STATUS_RENEW_IGNORED = 2'd2;

   localparam int          KEY_W   = 48;
   localparam int          TIME_W  = 30;
   localparam int          EXP_W   = 31;
   localparam int          COUNT_W = 7;
   localparam logic [6:0]  COUNT_MAX = 7'd127;
   localparam logic [29:0] TTL_RESET = 30'd5;

   // Pass of the wave that travels down the chain.
   typedef enum logic {
      PH_SEARCH,
      PH_APPLY
   } phase_type;

   // Which kind of cell the apply pass writes.
   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_KEY,
      SEL_FREE,
      SEL_EXPIRED
   } sel_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPLY,
      ST_DONE
   } state_type;

   // Record handed from cell to cell, one cell per cycle.
   typedef struct packed {
      logic                 active;
      phase_type            phase;
      logic [1:0]           func;
      logic [KEY_W-1:0]     key;
      logic [TIME_W-1:0]    now;
      logic [EXP_W-1:0]     expiry;
      logic                 hit;
      logic                 hit_live;
      logic                 free_found;
      logic                 exp_found;
      sel_type              sel;
      logic                 taken;
      logic [COUNT_W-1:0]   count;
   } wave_type;

endpackage

`default_nettype wire

// File: rtl/ttl_cell.sv
`default_nettype none

module ttl_cell import ttl_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire wave_type wave_in,
   output wave_type      wave_out
);

   logic               valid_ff, valid_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [EXP_W-1:0]   exp_ff, exp_in;
   wave_type           wave_ff, wave_in_next;

   logic               match;
   logic               expired;
   logic               pick;
   logic               live;

   // Local compares against the passing wave.
   assign match   = valid_ff && (key_ff == wave_in.key);
   assign expired = exp_ff <= {1'b0, wave_in.now};

   // Search pass gathers flags; apply pass writes, purges and counts.
   always_comb begin
      wave_in_next = wave_in;
      valid_in     = valid_ff;
      key_in       = key_ff;
      exp_in       = exp_ff;
      pick         = 1'b0;
      live         = 1'b0;
      if (wave_in.active) begin
         if (wave_in.phase == PH_SEARCH) begin
            if (match && !wave_in.hit) begin
               wave_in_next.hit      = 1'b1;
               wave_in_next.hit_live = !expired;
            end
            if (!valid_ff) begin
               wave_in_next.free_found = 1'b1;
            end
            if (valid_ff && expired) begin
               wave_in_next.exp_found = 1'b1;
            end
         end else begin
            case (wave_in.sel)
               SEL_KEY:     pick = !wave_in.taken && match;
               SEL_FREE:    pick = !wave_in.taken && !valid_ff;
               SEL_EXPIRED: pick = !wave_in.taken && valid_ff && expired;
               default:     pick = 1'b0;
            endcase
            if (pick) begin
               valid_in           = 1'b1;
               key_in             = wave_in.key;
               exp_in             = wave_in.expiry;
               wave_in_next.taken = 1'b1;
            end else if (wave_in.func == FUNC_COUNT && valid_ff && expired) begin
               valid_in = 1'b0;
            end
            // Count with the contents this cell holds after the operation.
            live = valid_in && (exp_in > {1'b0, wave_in.now});
            if (live && wave_in.count != COUNT_MAX) begin
               wave_in_next.count = wave_in.count + 7'd1;
            end
         end
      end
   end

   // Valid bit and wave marker are control; key and expiry are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         wave_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in_next;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      exp_ff <= exp_in;
   end

   assign wave_out = wave_ff;

endmodule

`default_nettype wire

// File: rtl/ttl_ctrl.sv
`default_nettype none

module ttl_ctrl import ttl_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_func,
   input  wire logic [KEY_W-1:0]    req_token_key,
   input  wire logic [TIME_W-1:0]   req_current_time,
   input  wire logic [TIME_W-1:0]   ttl,
   output wave_type                 head,
   input  wire wave_type            tail,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [COUNT_W-1:0]       rsp_live_count
);

   state_type           state_ff, state_in;
   wave_type            head_ff, head_in;
   logic [1:0]          status_ff, status_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                take_req;
   logic                search_back;
   logic                apply_back;
   logic                load_rsp;
   sel_type             sel;
   logic [1:0]          status_pick;

   assign search_back = tail.active && (tail.phase == PH_SEARCH);
   assign apply_back  = tail.active && (tail.phase == PH_APPLY);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (take_req) state_in = ST_SEARCH;
         ST_SEARCH: if (search_back) state_in = ST_APPLY;
         ST_APPLY:  if (apply_back) state_in = ST_DONE;
         ST_DONE:   if (load_rsp) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs of the state machine.
   always_comb begin
      req_stall = 1'b1;
      take_req  = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            take_req  = req_valid;
         end
         ST_DONE: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Decide the target of the write from the search flags.
   always_comb begin
      sel         = SEL_NONE;
      status_pick = STATUS_DONE;
      case (tail.func)
         FUNC_GENERATE: begin
            if (tail.hit) begin
               sel = SEL_KEY;
            end else if (tail.free_found) begin
               sel = SEL_FREE;
            end else if (tail.exp_found) begin
               sel = SEL_EXPIRED;
            end else begin
               status_pick = STATUS_FULL;
            end
         end
         FUNC_RENEW: begin
            if (tail.hit && tail.hit_live) begin
               sel = SEL_KEY;
            end else begin
               status_pick = STATUS_RENEW_IGNORED;
            end
         end
         default: begin
            sel = SEL_NONE;
         end
      endcase
   end

   // Launch the search wave, then the apply wave, then capture the result.
   always_comb begin
      head_in        = head_ff;
      head_in.active = 1'b0;
      status_in      = status_ff;
      count_in       = count_ff;
      if (take_req) begin
         head_in.active     = 1'b1;
         head_in.phase      = PH_SEARCH;
         head_in.func       = req_func;
         head_in.key        = req_token_key;
         head_in.now        = req_current_time;
         head_in.expiry     = {1'b0, req_current_time} + {1'b0, ttl};
         head_in.hit        = 1'b0;
         head_in.hit_live   = 1'b0;
         head_in.free_found = 1'b0;
         head_in.exp_found  = 1'b0;
         head_in.sel        = SEL_NONE;
         head_in.taken      = 1'b0;
         head_in.count      = '0;
      end else if (state_ff == ST_SEARCH && search_back) begin
         head_in        = tail;
         head_in.active = 1'b1;
         head_in.phase  = PH_APPLY;
         head_in.sel    = sel;
         head_in.taken  = 1'b0;
         head_in.count  = '0;
         status_in      = status_pick;
      end
      if (state_ff == ST_APPLY && apply_back) begin
         count_in = tail.count;
      end
   end

   // Output register: holds a result while the next item is at work.
   always_comb begin
      rsp_valid_in  = load_rsp || (rsp_valid_ff && rsp_stall);
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (load_rsp) begin
         rsp_status_in = status_ff;
         rsp_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff.active <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign head           = head_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_live_count = rsp_count_ff;

endmodule

`default_nettype wire

// File: rtl/ttl_token_table_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_func, req_token_key, req_current_time
// rsp       out        rsp_valid/rsp_stall  rsp_status, rsp_live_count
// csr       in         csr_wr_en            csr_wr_data (time_to_live)
//
// A search wave and then an apply wave each walk the row of ENTRIES cells,
// one cell per cycle.
// One item is at work at a time; the next transfer is taken while a result waits.
// Reset is synchronous and clears every valid bit at once; there is no clearing pass.
// A stall on rsp holds the result register; the following item still finishes
// its work and waits in the controller until the result register frees.
`default_nettype none

module ttl_token_table_unit import ttl_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_func,
   input  wire logic [KEY_W-1:0]    req_token_key,
   input  wire logic [TIME_W-1:0]   req_current_time,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [COUNT_W-1:0]       rsp_live_count,
   input  wire logic                csr_wr_en,
   input  wire logic [TIME_W-1:0]   csr_wr_data
);

   logic [TIME_W-1:0] ttl_ff, ttl_in;
   wave_type          link [ENTRIES+1];

   // Lifetime register.
   assign ttl_in = csr_wr_en ? csr_wr_data : ttl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else begin
         ttl_ff <= ttl_in;
      end
   end

   ttl_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_token_key    (req_token_key),
      .req_current_time (req_current_time),
      .ttl              (ttl_ff),
      .head             (link[0]),
      .tail             (link[ENTRIES]),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_live_count   (rsp_live_count)
   );

   // Row of entry cells; each hands the wave to its neighbor.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ttl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wave_in  (link[i]),
         .wave_out (link[i+1])
      );
   end

endmodule

`default_nettype wire

// File: rtl/ttl_checker.sv
`default_nettype none

module ttl_checker import ttl_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_status,
   input  wire logic [COUNT_W-1:0] rsp_live_count
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pend_ff, pend_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Items accepted and not yet answered.
   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer) begin
         pend_in = pend_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A response never appears without an item behind it.
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an accepted item");

   // At most one item at work plus one result waiting.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many items outstanding");

   // Input closes after a transfer while the item walks the table.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("input open right after a transfer");

   // Results carry a defined code and a count no larger than the table.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= STATUS_RENEW_IGNORED) && (rsp_live_count <= ENTRIES))
      else $error("response out of range");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_live_count))
      else $error("stalled response changed");

endmodule

bind ttl_token_table_unit ttl_checker #(.ENTRIES(ENTRIES)) u_ttl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_live_count (rsp_live_count)
);

`default_nettype wire

// File: tb/sv/tb_ttl_token_table_unit.sv
module tb_ttl_token_table_unit;
   import ttl_pkg::*;

   localparam int ENTRIES     = 64;
   localparam int ITEM_CYCLES = 2 * ENTRIES + 4;
   localparam int RUN_LIMIT   = 1500000;
   localparam int HOLD_LEN    = 1200;
   localparam int POOL_DEPTH  = 128;
   localparam int REPORT_MAX  = 50;

   // The one func code that the block must leave without effect.
   localparam logic [1:0]        FUNC_UNUSED = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX    = '1;
   localparam logic [KEY_W-1:0]  KEY_MAX     = '1;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] live;
   } reply_type;

   // Block inputs start at known values.
   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func         = FUNC_COUNT;
   logic [KEY_W-1:0]    req_token_key    = '0;
   logic [TIME_W-1:0]   req_current_time = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [1:0]          rsp_status;
   logic [COUNT_W-1:0]  rsp_live_count;
   logic                csr_wr_en        = 1'b0;
   logic [TIME_W-1:0]   csr_wr_data      = '0;

   // Shadow copy of the token table and its lifetime register.
   logic                tok_valid  [ENTRIES] = '{default: 1'b0};
   logic [KEY_W-1:0]    tok_key    [ENTRIES] = '{default: '0};
   logic [EXP_W-1:0]    tok_expiry [ENTRIES] = '{default: '0};
   logic [TIME_W-1:0]   lifetime             = TTL_RESET;

   reply_type           replies_due [$];
   int unsigned         error_count = 0;
   longint unsigned     cycle_count = 0;

   // Idle and stall controls of the two sides.
   bit                  idle_on     = 1'b1;
   int unsigned         gap_pct     = 15;
   int unsigned         stall_pct   = 15;
   int unsigned         burst_left  = 0;
   logic                hold_start  = 1'b0;
   logic                hold_active = 1'b0;

   // Random traffic state.
   logic [KEY_W-1:0]    key_pool [POOL_DEPTH];
   int unsigned         pool_size   = 1;
   logic [TIME_W-1:0]   traffic_now = '0;

   ttl_token_table_unit #(.ENTRIES(ENTRIES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_token_key    (req_token_key),
      .req_current_time (req_current_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_live_count   (rsp_live_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one operation to the shadow table and returns its status and live count.
   function automatic reply_type token_table_apply(input logic [1:0] func,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [TIME_W-1:0] now);
      reply_type        r;
      logic [EXP_W-1:0] expiry;
      logic [EXP_W-1:0] now_x;
      int               hit_slot;
      int               free_slot;
      int               stale_slot;
      int               slot;
      int unsigned      live;
      now_x      = {1'b0, now};
      expiry     = now_x + {1'b0, lifetime};
      r.status   = STATUS_DONE;
      hit_slot   = -1;
      free_slot  = -1;
      stale_slot = -1;
      live       = 0;

      // Lowest slot of each kind; the stale slot only matters when none is free.
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (tok_valid[i] && tok_key[i] == key) hit_slot = i;
         if (!tok_valid[i]) free_slot = i;
         if (tok_expiry[i] <= now_x) stale_slot = i;
      end

      case (func)
         FUNC_GENERATE: begin
            slot = (hit_slot >= 0) ? hit_slot : (free_slot >= 0) ? free_slot : stale_slot;
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               tok_valid[slot]  = 1'b1;
               tok_key[slot]    = key;
               tok_expiry[slot] = expiry;
            end
         end
         FUNC_RENEW: begin
            if (hit_slot < 0 || tok_expiry[hit_slot] <= now_x) begin
               r.status = STATUS_RENEW_IGNORED;
            end else begin
               tok_expiry[hit_slot] = expiry;
            end
         end
         FUNC_COUNT: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tok_valid[i] && tok_expiry[i] <= now_x) tok_valid[i] = 1'b0;
            end
         end
         default: ;
      endcase

      for (int i = 0; i < ENTRIES; i++) begin
         if (tok_valid[i] && tok_expiry[i] > now_x) live++;
      end
      r.live = (live > COUNT_MAX) ? COUNT_MAX : live[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[KEY_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] time_after(input logic [TIME_W-1:0] t,
                                                    input int unsigned step);
      return (TIME_MAX - t < step) ? TIME_MAX : TIME_W'(t + step);
   endfunction

   function automatic void refill_key_pool(input int unsigned size);
      pool_size = size;
      foreach (key_pool[i]) key_pool[i] = random_key();
   endfunction

   // Compares one rsp transfer with the oldest outstanding prediction.
   function automatic void check_reply();
      reply_type want;
      if (replies_due.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("%0t: rsp transfer with none expected: actual status %0d live_count %0d",
                     $time, rsp_status, rsp_live_count);
         return;
      end
      want = replies_due.pop_front();
      if (rsp_status !== want.status || rsp_live_count !== want.live) begin
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("%0t: rsp mismatch: expected status %0d live_count %0d, actual %0d %0d",
                     $time, want.status, want.live, rsp_status, rsp_live_count);
      end
   endfunction

   // Receiver: checks each transfer and stalls in random bursts or a long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_reply();
      if (burst_left != 0) begin
         burst_left--;
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
         burst_left = $urandom_range(1, 14);
      end
      rsp_stall <= hold_active || (burst_left != 0);
   end

   // Long receiver hold-off, counted here so the sender keeps offering items meanwhile.
   initial begin
      forever begin
         do @(posedge clock); while (!hold_start);
         hold_start  <= 1'b0;
         hold_active <= 1'b1;
         repeat (HOLD_LEN) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offers one request and records its prediction once the transfer happens.
   task automatic send_request(input logic [1:0] func, input logic [KEY_W-1:0] key,
                               input logic [TIME_W-1:0] now);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_token_key    <= key;
      req_current_time <= now;
      do @(posedge clock); while (req_stall);
      replies_due.push_back(token_table_apply(func, key, now));
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // The lifetime register is only written while the block is idle.
   task automatic set_lifetime(input logic [TIME_W-1:0] ttl);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ttl;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lifetime = ttl;
   endtask

   // Random mix of operations over the key pool, with time mostly moving forward.
   task automatic send_random_items(input int unsigned n);
      int unsigned      pick;
      logic [1:0]       func;
      logic [KEY_W-1:0] key;
      logic [TIME_W-1:0] stamp;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         func = (pick < 48) ? FUNC_GENERATE :
                (pick < 72) ? FUNC_RENEW    :
                (pick < 94) ? FUNC_COUNT    : FUNC_UNUSED;
         key  = ($urandom_range(0, 9) == 0) ? random_key()
                                            : key_pool[$urandom_range(0, pool_size - 1)];
         if ($urandom_range(0, 29) == 0) begin
            traffic_now = time_after(traffic_now, $urandom_range(10, 500));
         end else begin
            traffic_now = time_after(traffic_now, $urandom_range(0, 3));
         end
         stamp = traffic_now;
         // Now and then a request carries a time from the past.
         if ($urandom_range(0, 32) == 0) begin
            stamp = (stamp > 50) ? TIME_W'(stamp - $urandom_range(1, 50)) : '0;
         end
         send_request(func, key, stamp);
      end
   endtask

   // Each operation at the field extremes, with the default lifetime of five.
   task automatic test_directed_ops();
      send_request(FUNC_COUNT,    KEY_MAX,            30'd0);
      send_request(FUNC_RENEW,    48'h0,              30'd0);
      send_request(FUNC_GENERATE, 48'h0,              30'd0);
      send_request(FUNC_GENERATE, KEY_MAX,            30'd1);
      send_request(FUNC_GENERATE, 48'hAAAA_AAAA_AAAA, 30'd2);
      send_request(FUNC_GENERATE, 48'h5555_5555_5555, 30'd2);
      send_request(FUNC_RENEW,    48'h0,              30'd3);
      send_request(FUNC_UNUSED,   48'h5555_5555_5555, 30'd4);
      // Renew exactly at expiry is refused.
      send_request(FUNC_RENEW,    KEY_MAX,            30'd6);
      send_request(FUNC_COUNT,    48'h1234_5678_9ABC, 30'd7);
      // Generate on a key that is present but expired overwrites it in place.
      send_request(FUNC_GENERATE, 48'h0,              30'd20);
      send_request(FUNC_RENEW,    KEY_MAX,            30'd21);
      // Time going backward.
      send_request(FUNC_COUNT,    48'h0,              30'd10);
      send_request(FUNC_GENERATE, 48'h8000_0000_0001, TIME_MAX);
      send_request(FUNC_COUNT,    48'h0,              TIME_MAX);
   endtask

   // Zero, largest and smallest nonzero lifetimes.
   task automatic test_lifetime_extremes();
      set_lifetime('0);
      send_request(FUNC_GENERATE, 48'h1, 30'd100);
      send_request(FUNC_RENEW,    48'h1, 30'd100);
      set_lifetime(TIME_MAX);
      send_request(FUNC_GENERATE, 48'h2, TIME_MAX);
      send_request(FUNC_RENEW,    48'h2, TIME_MAX);
      // Short lifetime replaces the long-lived tokens so the table can drain.
      set_lifetime(30'd1);
      send_request(FUNC_GENERATE, 48'h2,              30'd50);
      send_request(FUNC_GENERATE, 48'h8000_0000_0001, 30'd50);
      send_request(FUNC_COUNT,    48'h0,              30'd60);
   endtask

   // Fills every slot, overflows, then reuses expired slots.
   task automatic test_table_full();
      logic [KEY_W-1:0]  keys [ENTRIES + 2];
      logic [TIME_W-1:0] base;
      set_lifetime(30'd1000);
      base = 30'd1000;
      foreach (keys[i]) keys[i] = random_key();
      send_request(FUNC_COUNT, 48'h0, base);
      for (int i = 0; i < ENTRIES + 2; i++) begin
         send_request(FUNC_GENERATE, keys[i], TIME_W'(base + i));
      end
      send_request(FUNC_GENERATE, keys[ENTRIES], base + 30'd70);
      send_request(FUNC_RENEW,    keys[0],       base + 30'd70);
      send_request(FUNC_GENERATE, keys[ENTRIES],     base + 30'd1003);
      send_request(FUNC_GENERATE, keys[ENTRIES + 1], base + 30'd1003);
      send_request(FUNC_RENEW,    keys[3],           base + 30'd1003);
      send_request(FUNC_COUNT,    48'h0,             base + 30'd1003);
   endtask

   // Rounds of random traffic, each with its own lifetime, key pool and idling.
   task automatic test_random_traffic();
      logic [TIME_W-1:0] ttl;
      for (int round = 0; round < 10; round++) begin
         case (round)
            0:       ttl = 30'd1;
            1:       ttl = 30'd20;
            2:       ttl = 30'd150;
            3:       ttl = TIME_MAX;
            4:       ttl = '0;
            5:       ttl = 30'd400;
            default: ttl = TIME_W'($urandom_range(1, 2000));
         endcase
         set_lifetime(ttl);
         refill_key_pool($urandom_range(8, 110));
         traffic_now = (round == 7) ? TIME_MAX - 30'd400
                                    : TIME_W'($urandom_range(0, TIME_MAX - 30'd100000));
         idle_on   = 1'b1;
         gap_pct   = (round % 3 == 0) ? 0 : $urandom_range(5, 40);
         stall_pct = (round % 4 == 1) ? 0 : $urandom_range(5, 40);
         send_random_items(140);
      end
   endtask

   // Receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      set_lifetime(30'd50);
      refill_key_pool(40);
      idle_on    = 1'b0;
      hold_start <= 1'b1;
      send_random_items(12);
      drain_replies();
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_steady_tail();
      set_lifetime(30'd300);
      refill_key_pool(70);
      idle_on = 1'b0;
      send_random_items(100);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_lifetime_extremes();
      test_table_full();
      test_random_traffic();
      test_backpressure();
      test_steady_tail();
      drain_replies();
      repeat (2 * ITEM_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
